@@ hdl/amts_pkg.sv @@
package amts_pkg;

    // item function codes
    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_QUERY = 2'd2
    } t_func;

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_W = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_H = 1'b1;

    // region size after reset
    localparam logic [CFG_DATA_W-1:0] REGION_RESET = 7'd64;

    // input word
    typedef struct packed {
        logic [1:0] func;
        logic [5:0] src_x;
        logic [5:0] src_y;
        logic       opaque;
        logic [6:0] query_x;
        logic [6:0] query_y;
    } t_in_word;

    // trimmed box as reported
    typedef struct packed {
        logic [6:0] box_x;
        logic [6:0] box_y;
        logic [6:0] box_w;
        logic [6:0] box_h;
    } t_box;

    // result word
    typedef struct packed {
        logic       solid;
        logic [6:0] box_x;
        logic [6:0] box_y;
        logic [6:0] box_w;
        logic [6:0] box_h;
    } t_out_word;

    // query decode carried alongside the memory read
    typedef struct packed {
        logic hit;    // query lands inside a non-empty box
        logic below;  // lower half with a row below inside the box
        logic right;  // right half with a column to the right inside the box
        logic left;   // left half with a column to the left inside the box
    } t_qry_ctl;

endpackage

@@ hdl/amts_in_if.sv @@
interface amts_in_if;
    logic               valid;
    logic               ready;
    amts_pkg::t_in_word word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

@@ hdl/amts_out_if.sv @@
interface amts_out_if;
    logic                valid;
    logic                ready;
    amts_pkg::t_out_word word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

@@ hdl/amts_mask_mem.sv @@
module amts_mask_mem #(
    parameter int MAX_SIDE = 64,
    parameter int CW       = $clog2(MAX_SIDE)
) (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [CW-1:0]       i_wr_row,
    input  logic [CW-1:0]       i_wr_col,
    input  logic                i_wr_bit,
    input  logic                i_rd_en,
    input  logic [CW-1:0]       i_rd_row_a,
    input  logic [CW-1:0]       i_rd_row_b,
    output logic [MAX_SIDE-1:0] o_row_a,
    output logic [MAX_SIDE-1:0] o_row_b
);

    // one row of mask bits per entry
    logic [MAX_SIDE-1:0] r_mem [MAX_SIDE];
    logic [MAX_SIDE-1:0] r_row_a;
    logic [MAX_SIDE-1:0] r_row_b;

    // single bit write into the addressed row
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_row][i_wr_col] <= i_wr_bit;
        end
    end

    // two registered row reads, held while i_rd_en is low
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_row_a <= r_mem[i_rd_row_a];
            r_row_b <= r_mem[i_rd_row_b];
        end
    end

    assign o_row_a = r_row_a;
    assign o_row_b = r_row_b;

endmodule

@@ hdl/amts_box_track.sv @@
module amts_box_track #(
    parameter int MAX_SIDE = 64,
    parameter int CW       = $clog2(MAX_SIDE)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [amts_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [amts_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_accept,
    input  amts_pkg::t_in_word                 i_word,
    output logic                               o_wr_en,
    output logic [CW-1:0]                      o_wr_row,
    output logic [CW-1:0]                      o_wr_col,
    output logic                               o_wr_bit,
    output logic [CW-1:0]                      o_rd_row_a,
    output logic [CW-1:0]                      o_rd_row_b,
    output logic [CW-1:0]                      o_col,
    output amts_pkg::t_qry_ctl                 o_ctl,
    output amts_pkg::t_box                     o_box
);
    import amts_pkg::*;

    localparam int BW = $clog2(MAX_SIDE + 1);
    localparam int AW = ((BW > 7) ? BW : 7) + 1;

    logic [CFG_DATA_W-1:0] r_region_w;
    logic [CFG_DATA_W-1:0] r_region_h;
    logic [BW-1:0] r_min_col, r_max_col, r_min_row, r_max_row;
    logic [BW-1:0] n_min_col, n_max_col, n_min_row, n_max_row;
    logic          r_any, n_any;

    logic [AW-1:0] rw_c, rh_c, sx_w, sy_w, qx_w, qy_w;
    logic [AW-1:0] bx, by, bw, bh, x, y, y1;
    logic          wr_ok;
    t_func         func;

    // region registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_w <= REGION_RESET;
            r_region_h <= REGION_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REGION_W: r_region_w <= i_cfg_data;
                CFG_REGION_H: r_region_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp region to between one and the store size
    always_comb begin
        if (r_region_w == '0) begin
            rw_c = AW'(1);
        end else if (AW'(r_region_w) > AW'(MAX_SIDE)) begin
            rw_c = AW'(MAX_SIDE);
        end else begin
            rw_c = AW'(r_region_w);
        end
        if (r_region_h == '0) begin
            rh_c = AW'(1);
        end else if (AW'(r_region_h) > AW'(MAX_SIDE)) begin
            rh_c = AW'(MAX_SIDE);
        end else begin
            rh_c = AW'(r_region_h);
        end
    end

    assign func  = t_func'(i_word.func);
    assign sx_w  = AW'(i_word.src_x);
    assign sy_w  = AW'(i_word.src_y);
    assign qx_w  = AW'(i_word.query_x);
    assign qy_w  = AW'(i_word.query_y);
    assign wr_ok = (func == FUNC_WRITE) && (sx_w < rw_c) && (sy_w < rh_c);

    // box update for the item on the input
    always_comb begin
        n_min_col = r_min_col;
        n_max_col = r_max_col;
        n_min_row = r_min_row;
        n_max_row = r_max_row;
        n_any     = r_any;
        case (func)
            FUNC_START: begin
                n_min_col = BW'(MAX_SIDE);
                n_max_col = '0;
                n_min_row = BW'(MAX_SIDE);
                n_max_row = '0;
                n_any     = 1'b0;
            end
            FUNC_WRITE: begin
                if (wr_ok && i_word.opaque) begin
                    if (sx_w < AW'(r_min_col)) n_min_col = sx_w[BW-1:0];
                    if (sx_w > AW'(r_max_col)) n_max_col = sx_w[BW-1:0];
                    if (sy_w < AW'(r_min_row)) n_min_row = sy_w[BW-1:0];
                    if (sy_w > AW'(r_max_row)) n_max_row = sy_w[BW-1:0];
                    n_any = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_col <= BW'(MAX_SIDE);
            r_max_col <= '0;
            r_min_row <= BW'(MAX_SIDE);
            r_max_row <= '0;
            r_any     <= 1'b0;
        end else if (i_accept) begin
            r_min_col <= n_min_col;
            r_max_col <= n_max_col;
            r_min_row <= n_min_row;
            r_max_row <= n_max_row;
            r_any     <= n_any;
        end
    end

    // box after this item
    assign bx = n_any ? AW'(n_min_col) : '0;
    assign by = n_any ? AW'(n_min_row) : '0;
    assign bw = n_any ? (AW'(n_max_col) - AW'(n_min_col) + AW'(1)) : '0;
    assign bh = n_any ? (AW'(n_max_row) - AW'(n_min_row) + AW'(1)) : '0;

    assign o_box.box_x = bx[6:0];
    assign o_box.box_y = by[6:0];
    assign o_box.box_w = bw[6:0];
    assign o_box.box_h = bh[6:0];

    // query decode in doubled coordinates
    always_comb begin
        o_ctl.hit   = (func == FUNC_QUERY) && n_any && (qx_w < (bw << 1)) &&
                      (qy_w < (bh << 1));
        o_ctl.below = qy_w[0] && (qy_w < ((bh << 1) - AW'(1)));
        o_ctl.right = qx_w[0] && (qx_w < ((bw << 1) - AW'(1)));
        o_ctl.left  = !qx_w[0] && (qx_w != '0);
    end

    assign x  = bx + (qx_w >> 1);
    assign y  = by + (qy_w >> 1);
    assign y1 = y + AW'(1);

    assign o_col      = x[CW-1:0];
    assign o_rd_row_a = o_ctl.hit ? y[CW-1:0] : '0;
    assign o_rd_row_b = (o_ctl.hit && o_ctl.below) ? y1[CW-1:0] : o_rd_row_a;

    // store write for writes inside the region
    assign o_wr_en  = i_accept && wr_ok;
    assign o_wr_row = sy_w[CW-1:0];
    assign o_wr_col = sx_w[CW-1:0];
    assign o_wr_bit = i_word.opaque;

    // a non-empty box never has its bounds crossed
    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_any |-> (r_min_col <= r_max_col) && (r_min_row <= r_max_row))
        else $error("box bounds crossed");

    // a write outside the region leaves the box alone
    a_region_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (func == FUNC_WRITE) && !wr_ok) |=>
        ($stable(r_min_col) && $stable(r_max_col) && $stable(r_min_row) &&
         $stable(r_max_row) && $stable(r_any)))
        else $error("write outside region changed box");

endmodule

@@ hdl/amts_smooth.sv @@
module amts_smooth #(
    parameter int MAX_SIDE = 64,
    parameter int CW       = $clog2(MAX_SIDE)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [CW-1:0]       i_col,
    input  amts_pkg::t_qry_ctl  i_ctl,
    input  amts_pkg::t_box      i_box,
    input  logic [MAX_SIDE-1:0] i_row_a,
    input  logic [MAX_SIDE-1:0] i_row_b,
    input  logic                i_out_ready,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output amts_pkg::t_out_word o_out_word
);
    import amts_pkg::*;

    logic          r_s1_valid;
    logic [CW-1:0] r_s1_col;
    t_qry_ctl      r_s1_ctl;
    t_box          r_s1_box;
    logic          r_o_valid;
    t_out_word     r_o_word;

    logic          out_free, advance, s, solid;
    logic [CW-1:0] xp, xm;

    assign out_free   = !r_o_valid || i_out_ready;
    assign advance    = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;

    // stage waiting for the row read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_col <= i_col;
            r_s1_ctl <= i_ctl;
            r_s1_box <= i_box;
        end
    end

    // smoothing of an empty pixel from its neighbors
    assign xp = r_s1_col + CW'(1);
    assign xm = r_s1_col - CW'(1);

    always_comb begin
        s = i_row_a[r_s1_col];
        if (!s && r_s1_ctl.below && i_row_b[r_s1_col] &&
            ((r_s1_ctl.right && i_row_a[xp]) || (r_s1_ctl.left && i_row_a[xm]))) begin
            s = 1'b1;
        end
        solid = r_s1_ctl.hit && s;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (advance) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_o_word.solid <= solid;
            r_o_word.box_x <= r_s1_box.box_x;
            r_o_word.box_y <= r_s1_box.box_y;
            r_o_word.box_w <= r_s1_box.box_w;
            r_o_word.box_h <= r_s1_box.box_h;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_word  = r_o_word;

    // no word taken while both stages are full and the output stalls
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_o_valid && !i_out_ready) |-> !i_accept)
        else $error("word taken into a full pipeline");

    // a solid result always comes with a non-empty box
    a_solid_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_word.solid) |->
        ((r_o_word.box_w != '0) && (r_o_word.box_h != '0)))
        else $error("solid pixel reported with empty box");

endmodule

@@ hdl/alpha_mask_trim_and_smooth_upscale_core.sv @@
// Trimmed 2x upscale of a binary opacity mask with edge smoothing.
// Input channel i_in takes one word per cycle while i_in.ready is high:
// start a frame, write one source pixel, or query one upscaled pixel
// inside the trimmed box. Every accepted word gives exactly one result
// word on o_out, in order, carrying the box after that word and, for
// queries, the solid bit. Region width and height are set through the
// write port i_cfg_*, which the user must write only while the block is
// idle (the block does not enforce this); values outside 1..MAX_SIDE are
// clamped. On acceptance on i_in, two mask rows are loaded from the
// dual-read row memory into its read registers; the smoothed result then
// passes into the output register, which raises o_out.valid. The block
// takes one word per cycle while o_out does not stall; the row memory
// takes one write and one pair of row reads per cycle.
// Reset clears the box to empty, sets both region sizes to 64 and empties
// the pipeline; the mask memory is not cleared, so the user must write
// every pixel before it is queried (the block does not enforce this).
// When the receiver stalls, the output word holds and one more word can
// sit behind it; after that i_in.ready drops until o_out drains.
module alpha_mask_trim_and_smooth_upscale_core #(
    parameter int MAX_SIDE = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [amts_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [amts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    amts_in_if.sink                         i_in,
    amts_out_if.source                      o_out
);
    import amts_pkg::*;

    localparam int CW = $clog2(MAX_SIDE);

    logic                accept;
    logic                in_ready;
    logic                wr_en, wr_bit;
    logic [CW-1:0]       wr_row, wr_col, rd_row_a, rd_row_b, col;
    logic [MAX_SIDE-1:0] row_a, row_b;
    t_qry_ctl            ctl;
    t_box                box;

    assign accept     = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    // box tracking, region check and query decode
    amts_box_track #(
        .MAX_SIDE (MAX_SIDE),
        .CW       (CW)
    ) u_box (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_word     (i_in.word),
        .o_wr_en    (wr_en),
        .o_wr_row   (wr_row),
        .o_wr_col   (wr_col),
        .o_wr_bit   (wr_bit),
        .o_rd_row_a (rd_row_a),
        .o_rd_row_b (rd_row_b),
        .o_col      (col),
        .o_ctl      (ctl),
        .o_box      (box)
    );

    // mask rows
    amts_mask_mem #(
        .MAX_SIDE (MAX_SIDE),
        .CW       (CW)
    ) u_mem (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_row   (wr_row),
        .i_wr_col   (wr_col),
        .i_wr_bit   (wr_bit),
        .i_rd_en    (accept),
        .i_rd_row_a (rd_row_a),
        .i_rd_row_b (rd_row_b),
        .o_row_a    (row_a),
        .o_row_b    (row_b)
    );

    // smoothing and output staging
    amts_smooth #(
        .MAX_SIDE (MAX_SIDE),
        .CW       (CW)
    ) u_smooth (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_col       (col),
        .i_ctl       (ctl),
        .i_box       (box),
        .i_row_a     (row_a),
        .i_row_b     (row_b),
        .i_out_ready (o_out.ready),
        .o_in_ready  (in_ready),
        .o_out_valid (o_out.valid),
        .o_out_word  (o_out.word)
    );

endmodule
